/* src/assert_macros.svh */
// Assertion macros shared by the ring buffer RTL.
// Each macro assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZCRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring buffer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ZCRB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring buffer assertion failed");

`endif

/* src/zcrb_pkg.sv */
// Shared types and constants for the zero-copy byte ring buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
package zcrb_pkg;

  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int AMT_W      = 9;
  localparam int ADDR_W     = 8;
  localparam int CFG_W      = 9;
  localparam int RESET_SIZE = 256;
  localparam int MIN_SIZE   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_COMMIT    = 3'd2,
    CMD_RELEASE   = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_RAW_STORE = 3'd5,
    CMD_RAW_LOAD  = 3'd6,
    CMD_STATUS    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic report;
  } ctl_t;

endpackage

/* src/zcrb_ctrl.sv */
// Controller state machine for the ring buffer: sequences capture, execute and report.
// Depends on zcrb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zcrb_ctrl
  import zcrb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output ctl_t ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC:   state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        ctl.capture = start;
      end
      ST_EXEC:   ctl.exec   = 1'b1;
      ST_REPORT: ctl.report = 1'b1;
      default:   busy       = 1'b1;
    endcase
  end

  `ZCRB_ASSERT_NXT(a_start_to_exec, ctl.capture, ctl.exec)
  `ZCRB_ASSERT_NXT(a_exec_to_report, ctl.exec, ctl.report && busy)
  `ZCRB_ASSERT_IMP(a_one_command, 1'b1, $onehot0({ctl.capture, ctl.exec, ctl.report}))

endmodule

/* src/zcrb_datapath.sv */
// Datapath for the ring buffer: byte store, pointers, ring size and result registers.
// Depends on zcrb_pkg and assert_macros.svh; driven by zcrb_ctrl commands.
`include "assert_macros.svh"

module zcrb_datapath
  import zcrb_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BYTE_W-1:0] in_data_in,
  input  logic [AMT_W-1:0]  in_amount,
  input  logic [ADDR_W-1:0] in_raw_addr,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_data_out,
  output logic              out_ok,
  output logic [BYTE_W-1:0] out_write_pos,
  output logic [BYTE_W-1:0] out_read_pos,
  output logic [BYTE_W-1:0] out_fill_count,
  output logic [BYTE_W-1:0] out_write_span,
  output logic [BYTE_W-1:0] out_read_span
);

  localparam int PW = $clog2(DEPTH);
  localparam int SW = PW + 1;
  localparam int AW = ((PW > AMT_W) ? PW : AMT_W) + 1;
  localparam int RST_SIZE = (RESET_SIZE > DEPTH) ? DEPTH : RESET_SIZE;

  logic [BYTE_W-1:0] mem [DEPTH];

  // Captured command word.
  cmd_t              cmd_r;
  logic [BYTE_W-1:0] data_r;
  logic [AMT_W-1:0]  amount_r;
  logic [ADDR_W-1:0] addr_r;

  logic [SW-1:0] size_r;
  logic [SW-1:0] size_nxt;
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic          ok_r;
  logic          ok_nxt;
  logic          sel_mem_r;
  logic          sel_mem_nxt;
  logic [BYTE_W-1:0] mem_q_r;

  logic          mem_we;
  logic [PW-1:0] mem_wa;
  logic          mem_re;
  logic [PW-1:0] mem_ra;
  logic          raw_ok;
  logic [PW-1:0] push_nxt;
  logic [31:0]   cfg_ext;

  logic [SW-1:0] fill;
  logic [SW-1:0] wspan;
  logic [SW-1:0] rspan;
  logic [SW-1:0] wr_ext;
  logic [SW-1:0] rd_ext;

  logic              out_valid_r;
  logic [BYTE_W-1:0] data_out_r;
  logic              ok_out_r;
  logic [BYTE_W-1:0] write_pos_r;
  logic [BYTE_W-1:0] read_pos_r;
  logic [BYTE_W-1:0] fill_r;
  logic [BYTE_W-1:0] wspan_r;
  logic [BYTE_W-1:0] rspan_r;

  // Pointer advance; reaching or passing the ring size wraps to zero.
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] ptr,
                                        input logic [AW-1:0] len,
                                        input logic [SW-1:0] size);
    logic [AW-1:0] sum;
    sum = AW'(ptr) + len;
    return (sum >= AW'(size)) ? '0 : sum[PW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= cmd_t'(in_cmd);
      data_r   <= in_data_in;
      amount_r <= in_amount;
      addr_r   <= in_raw_addr;
    end
  end

  // Out-of-range sizes are clamped once, when the register is written.
  always_comb begin
    cfg_ext = 32'(cfg_wdata);
    if (cfg_ext < 32'(MIN_SIZE)) cfg_ext = 32'(MIN_SIZE);
    if (cfg_ext > 32'(DEPTH)) cfg_ext = 32'(DEPTH);
    size_nxt = cfg_ext[SW-1:0];
  end

  assign raw_ok   = 32'(addr_r) < 32'(DEPTH);
  assign push_nxt = adv(wr_ptr_r, AW'(1), size_r);

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    ok_nxt      = 1'b1;
    sel_mem_nxt = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = wr_ptr_r;
    mem_re      = 1'b0;
    mem_ra      = rd_ptr_r;
    unique case (cmd_r)
      CMD_PUSH: begin
        if (push_nxt == rd_ptr_r) begin
          ok_nxt = 1'b0;
        end else begin
          mem_we     = 1'b1;
          wr_ptr_nxt = push_nxt;
        end
      end
      CMD_POP: begin
        if (rd_ptr_r == wr_ptr_r) begin
          ok_nxt = 1'b0;
        end else begin
          mem_re      = 1'b1;
          sel_mem_nxt = 1'b1;
          rd_ptr_nxt  = adv(rd_ptr_r, AW'(1), size_r);
        end
      end
      CMD_COMMIT: begin
        if (amount_r != '0) wr_ptr_nxt = adv(wr_ptr_r, AW'(amount_r), size_r);
      end
      CMD_RELEASE: rd_ptr_nxt = adv(rd_ptr_r, AW'(amount_r), size_r);
      CMD_CLEAR:   rd_ptr_nxt = wr_ptr_r;
      CMD_RAW_STORE: begin
        mem_we = raw_ok;
        mem_wa = PW'(addr_r);
      end
      CMD_RAW_LOAD: begin
        mem_re      = raw_ok;
        sel_mem_nxt = raw_ok;
        mem_ra      = PW'(addr_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && mem_we) mem[mem_wa] <= data_r;
    if (ctl.exec && mem_re) mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= SW'(RST_SIZE);
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else if (cfg_we) begin
      size_r   <= size_nxt;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else if (ctl.exec) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      ok_r      <= ok_nxt;
      sel_mem_r <= sel_mem_nxt;
    end
  end

  assign wr_ext = SW'(wr_ptr_r);
  assign rd_ext = SW'(rd_ptr_r);

  always_comb begin
    if (rd_ext <= wr_ext) fill = wr_ext - rd_ext;
    else fill = size_r + wr_ext - rd_ext;

    if (rd_ext > wr_ext) wspan = rd_ext - wr_ext - SW'(1);
    else if (rd_ext == '0) wspan = size_r - wr_ext - SW'(1);
    else wspan = size_r - wr_ext;

    if (wr_ext < rd_ext) rspan = size_r - rd_ext;
    else rspan = wr_ext - rd_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.report;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      data_out_r  <= sel_mem_r ? mem_q_r : '0;
      ok_out_r    <= ok_r;
      write_pos_r <= BYTE_W'(wr_ptr_r);
      read_pos_r  <= BYTE_W'(rd_ptr_r);
      fill_r      <= BYTE_W'(fill);
      wspan_r     <= BYTE_W'(wspan);
      rspan_r     <= BYTE_W'(rspan);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = data_out_r;
  assign out_ok         = ok_out_r;
  assign out_write_pos  = write_pos_r;
  assign out_read_pos   = read_pos_r;
  assign out_fill_count = fill_r;
  assign out_write_span = wspan_r;
  assign out_read_span  = rspan_r;

  `ZCRB_ASSERT_NXT(a_report_strobes, ctl.report, out_valid)
  `ZCRB_ASSERT_IMP(a_wr_in_ring, 1'b1, wr_ext < size_r)
  `ZCRB_ASSERT_IMP(a_rd_in_ring, 1'b1, rd_ext < size_r)

endmodule

/* src/zero_copy_byte_ring_buffer.sv */
// Top level of the zero-copy byte ring buffer: controller plus datapath.
// Depends on zcrb_pkg, zcrb_ctrl and zcrb_datapath.
//
//   channel  | handshake          | word
//   ---------+--------------------+-------------------------------------------
//   input    | start / busy       | in_cmd, in_data_in, in_amount, in_raw_addr
//   result   | out_valid (strobe) | out_data_out .. out_read_span
//   config   | cfg_we             | cfg_wdata (ring size)
//
// Each command passes through capture, execute (one access to the byte
// store, registered read), then report. busy is high during the execute and
// report steps; the result strobe comes in the cycle after the report step.
// Reset is synchronous; it clears the pointers and the strobe and sets the ring
// size to its full value.
// The receiver cannot stall; every result is shown for exactly one cycle.
module zero_copy_byte_ring_buffer
  import zcrb_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BYTE_W-1:0] in_data_in,
  input  logic [AMT_W-1:0]  in_amount,
  input  logic [ADDR_W-1:0] in_raw_addr,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_data_out,
  output logic              out_ok,
  output logic [BYTE_W-1:0] out_write_pos,
  output logic [BYTE_W-1:0] out_read_pos,
  output logic [BYTE_W-1:0] out_fill_count,
  output logic [BYTE_W-1:0] out_write_span,
  output logic [BYTE_W-1:0] out_read_span
);

  ctl_t ctl;

  zcrb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  zcrb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_cmd         (in_cmd),
    .in_data_in     (in_data_in),
    .in_amount      (in_amount),
    .in_raw_addr    (in_raw_addr),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out),
    .out_ok         (out_ok),
    .out_write_pos  (out_write_pos),
    .out_read_pos   (out_read_pos),
    .out_fill_count (out_fill_count),
    .out_write_span (out_write_span),
    .out_read_span  (out_read_span)
  );

endmodule

/* dv/zero_copy_byte_ring_buffer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the zero-copy byte ring buffer: directed and random commands.
// Depends on zcrb_pkg and the zero_copy_byte_ring_buffer RTL.
module zero_copy_byte_ring_buffer_test;
  import zcrb_pkg::*;

  localparam int STORE_DEPTH = 256;

  typedef struct {
    logic [7:0] data_out;
    logic       ok;
    logic [7:0] wpos;
    logic [7:0] rpos;
    logic [7:0] fill;
    logic [7:0] wspan;
    logic [7:0] rspan;
  } ring_word_t;

  // Tracks the ring state and the result words still to come from the block.
  class ring_tracker;
    logic [7:0]       mem [STORE_DEPTH];
    bit               written [STORE_DEPTH];
    int unsigned      wptr;
    int unsigned      rptr;
    logic [CFG_W-1:0] size_reg;
    ring_word_t       expected_words [$];
    int unsigned      n_fail;

    function new();
      wptr = 0;
      rptr = 0;
      size_reg = CFG_W'(RESET_SIZE);
      n_fail = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function int unsigned ring_len();
      int unsigned s;
      s = size_reg;
      if (s < MIN_SIZE) s = MIN_SIZE;
      if (s > STORE_DEPTH) s = STORE_DEPTH;
      return s;
    endfunction

    function int unsigned bump(int unsigned p, int unsigned n);
      return (p + n >= ring_len()) ? 0 : p + n;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      size_reg = v;
      wptr = 0;
      rptr = 0;
    endfunction

    // One slot is kept free, so a read pointer at 0 costs the last byte.
    function int unsigned free_span();
      if (rptr > wptr) return rptr - wptr - 1;
      else if (rptr == 0) return ring_len() - wptr - 1;
      else return ring_len() - wptr;
    endfunction

    function int unsigned held_span();
      if (wptr < rptr) return ring_len() - rptr;
      else return wptr - rptr;
    endfunction

    function bit pop_reads_unwritten();
      return (rptr != wptr) && !written[rptr];
    endfunction

    function void note_command(cmd_t c, logic [7:0] d, logic [8:0] amt, logic [7:0] a);
      ring_word_t  w;
      int unsigned s;
      int unsigned nxt;
      int unsigned fill;
      s = ring_len();
      w.data_out = 8'd0;
      w.ok = 1'b1;
      case (c)
        CMD_PUSH: begin
          nxt = bump(wptr, 1);
          if (nxt == rptr) begin
            w.ok = 1'b0;
          end else begin
            mem[wptr] = d;
            written[wptr] = 1'b1;
            wptr = nxt;
          end
        end
        CMD_POP: begin
          if (rptr == wptr) begin
            w.ok = 1'b0;
          end else begin
            w.data_out = mem[rptr];
            rptr = bump(rptr, 1);
          end
        end
        CMD_COMMIT: if (amt != 0) wptr = bump(wptr, amt);
        CMD_RELEASE: rptr = bump(rptr, amt);
        CMD_CLEAR: rptr = wptr;
        CMD_RAW_STORE: begin
          mem[a] = d;
          written[a] = 1'b1;
        end
        CMD_RAW_LOAD: w.data_out = mem[a];
        default: ;
      endcase
      fill = (rptr <= wptr) ? wptr - rptr : s + wptr - rptr;
      w.wpos = 8'(wptr);
      w.rpos = 8'(rptr);
      w.fill = 8'(fill);
      w.wspan = 8'(free_span());
      w.rspan = 8'(held_span());
      expected_words.push_back(w);
    endfunction

    function void cmp_field(string fname, logic [7:0] e, logic [7:0] g);
      if (e !== g) begin
        $error("%s: expected %0d, got %0d", fname, e, g);
        n_fail++;
      end
    endfunction

    function void check_result(ring_word_t got);
      ring_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("result word with no command outstanding");
        n_fail++;
        return;
      end
      exp_w = expected_words.pop_front();
      cmp_field("data_out", exp_w.data_out, got.data_out);
      cmp_field("ok", {7'd0, exp_w.ok}, {7'd0, got.ok});
      cmp_field("write_pos", exp_w.wpos, got.wpos);
      cmp_field("read_pos", exp_w.rpos, got.rpos);
      cmp_field("fill_count", exp_w.fill, got.fill);
      cmp_field("write_span", exp_w.wspan, got.wspan);
      cmp_field("read_span", exp_w.rspan, got.rspan);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  in_cmd;
  logic [BYTE_W-1:0] in_data_in;
  logic [AMT_W-1:0]  in_amount;
  logic [ADDR_W-1:0] in_raw_addr;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              out_valid;
  logic [BYTE_W-1:0] out_data_out;
  logic              out_ok;
  logic [BYTE_W-1:0] out_write_pos;
  logic [BYTE_W-1:0] out_read_pos;
  logic [BYTE_W-1:0] out_fill_count;
  logic [BYTE_W-1:0] out_write_span;
  logic [BYTE_W-1:0] out_read_span;

  ring_tracker      tracker;
  ring_word_t       got_word;
  int unsigned      items_sent;
  int unsigned      gapless_left;
  logic [CFG_W-1:0] ring_sizes [12];

  zero_copy_byte_ring_buffer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_data_in    (in_data_in),
    .in_amount     (in_amount),
    .in_raw_addr   (in_raw_addr),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_data_out  (out_data_out),
    .out_ok        (out_ok),
    .out_write_pos (out_write_pos),
    .out_read_pos  (out_read_pos),
    .out_fill_count(out_fill_count),
    .out_write_span(out_write_span),
    .out_read_span (out_read_span)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_word.data_out = out_data_out;
      got_word.ok = out_ok;
      got_word.wpos = out_write_pos;
      got_word.rpos = out_read_pos;
      got_word.fill = out_fill_count;
      got_word.wspan = out_write_span;
      got_word.rspan = out_read_span;
      tracker.check_result(got_word);
    end
  end

  // Mostly random gaps, with occasional back-to-back stretches.
  function automatic int unsigned pick_gap();
    if (gapless_left > 0) begin
      gapless_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      gapless_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [8:0] pick_amount();
    case ($urandom_range(0, 6))
      0: return 9'd0;
      1: return 9'd256;
      2: return 9'(tracker.ring_len() - 1);
      3: return 9'(tracker.ring_len());
      4: return 9'($urandom_range(0, 256));
      default: return 9'($urandom_range(0, 8));
    endcase
  endfunction

  task automatic send_word(cmd_t c, logic [7:0] d, logic [8:0] amt, logic [7:0] a);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_cmd <= c;
    in_data_in <= d;
    in_amount <= amt;
    in_raw_addr <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_command(c, d, amt, a);
    items_sent++;
  endtask

  // Never lets a pop or a raw load touch a store byte that was never written.
  task automatic issue(cmd_t c, logic [7:0] d, logic [8:0] amt, logic [7:0] a);
    if (c == CMD_POP && tracker.pop_reads_unwritten())
      send_word(CMD_RAW_STORE, 8'($urandom), amt, 8'(tracker.rptr));
    if (c == CMD_RAW_LOAD && !tracker.written[a]) c = CMD_RAW_STORE;
    send_word(c, d, amt, a);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ring_size(logic [CFG_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_size(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_step();
    int unsigned n;
    int unsigned span;
    int unsigned base;
    case ($urandom_range(0, 9))
      0, 1: issue(cmd_t'($urandom_range(0, 7)), 8'($urandom), pick_amount(),
                  8'($urandom));
      2: begin
        // Zero-copy fill: write up to the free span directly, then commit what was written.
        span = tracker.free_span();
        n = (span > 12 && $urandom_range(0, 7) != 0) ? $urandom_range(0, 12)
                                                      : $urandom_range(0, span);
        base = tracker.wptr;
        for (int i = 0; i < n; i++)
          issue(CMD_RAW_STORE, 8'($urandom), pick_amount(), 8'(base + i));
        issue(CMD_COMMIT, 8'($urandom), 9'(n), 8'($urandom));
      end
      3: begin
        // Zero-copy drain: read up to the held span directly, then release what was read.
        span = tracker.held_span();
        n = (span > 12 && $urandom_range(0, 7) != 0) ? $urandom_range(0, 12)
                                                      : $urandom_range(0, span);
        base = tracker.rptr;
        for (int i = 0; i < n; i++)
          issue(CMD_RAW_LOAD, 8'($urandom), pick_amount(), 8'(base + i));
        issue(CMD_RELEASE, 8'($urandom), 9'(n), 8'($urandom));
      end
      4, 5: begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          issue(CMD_PUSH, 8'($urandom), pick_amount(), 8'($urandom));
      end
      6, 7: begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          issue(CMD_POP, 8'($urandom), pick_amount(), 8'($urandom));
      end
      8: issue(cmd_t'($urandom_range(0, 1) ? CMD_COMMIT : CMD_RELEASE), 8'($urandom),
               pick_amount(), 8'($urandom));
      default: issue(cmd_t'($urandom_range(0, 1) ? CMD_CLEAR : CMD_STATUS),
                     8'($urandom), pick_amount(), 8'($urandom));
    endcase
  endtask

  initial begin
    tracker = new();
    items_sent = 0;
    gapless_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_STATUS;
    in_data_in = '0;
    in_amount = '0;
    in_raw_addr = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset ring size of 256.
    issue(CMD_STATUS, 8'h00, 9'd0, 8'h00);
    issue(CMD_POP, 8'h00, 9'd0, 8'h00);
    issue(CMD_PUSH, 8'h00, 9'd0, 8'h00);
    issue(CMD_PUSH, 8'hFF, 9'd0, 8'h00);
    issue(CMD_POP, 8'h00, 9'd0, 8'h00);
    issue(CMD_POP, 8'h00, 9'd0, 8'h00);
    issue(CMD_POP, 8'h00, 9'd0, 8'h00);
    issue(CMD_RAW_STORE, 8'hA5, 9'd0, 8'h00);
    issue(CMD_RAW_STORE, 8'h5A, 9'd0, 8'hFF);
    issue(CMD_RAW_LOAD, 8'h00, 9'd0, 8'hFF);
    issue(CMD_RAW_LOAD, 8'h00, 9'd0, 8'h00);
    issue(CMD_COMMIT, 8'h00, 9'd0, 8'h00);
    issue(CMD_RELEASE, 8'h00, 9'd0, 8'h00);
    issue(CMD_COMMIT, 8'h00, 9'd253, 8'h00);
    issue(CMD_PUSH, 8'h3C, 9'd0, 8'h00);
    issue(CMD_PUSH, 8'hC3, 9'd0, 8'h00);
    issue(CMD_PUSH, 8'h11, 9'd0, 8'h00);
    issue(CMD_RELEASE, 8'h00, 9'd256, 8'h00);
    issue(CMD_POP, 8'h00, 9'd0, 8'h00);
    issue(CMD_CLEAR, 8'h00, 9'd0, 8'h00);
    issue(CMD_COMMIT, 8'h00, 9'd256, 8'h00);
    issue(CMD_RELEASE, 8'h00, 9'd255, 8'h00);
    issue(CMD_STATUS, 8'hFF, 9'd511 & 9'd256, 8'hFF);

    // Ring sizes of 0 and 1 act as 2, and sizes above 256 act as 256.
    ring_sizes = '{9'd2, 9'd511, 9'd0, 9'd3, 9'd256, 9'd1, 9'd0, 9'd255, 9'd0,
                   9'd257, 9'd0, 9'd4};
    ring_sizes[6] = 9'($urandom_range(2, 256));
    ring_sizes[8] = 9'($urandom_range(2, 40));
    ring_sizes[10] = 9'($urandom_range(2, 511));
    foreach (ring_sizes[p]) begin
      write_ring_size(ring_sizes[p]);
      while (items_sent < 25 + (p + 1) * 137) random_step();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (tracker.expected_words.size() != 0) begin
      $error("%0d result words never arrived", tracker.expected_words.size());
      tracker.n_fail += tracker.expected_words.size();
    end
    if (tracker.n_fail == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
